// ===== hw/rtl/einr_pkg.sv =====
// ----------------------------------------------------------------------------
// einr_pkg
// Shared constants and sequencer states for the exact integer nth root core.
// ----------------------------------------------------------------------------
package einr_pkg;

	localparam int VALUE_BITS_DEF = 31;
	localparam int DEG_BITS       = 5;
	localparam int BASE_BITS      = 16;

	localparam logic [BASE_BITS-1:0] MIN_BASE = 16'd2;
	localparam logic [BASE_BITS-1:0] MAX_BASE = 16'd65535;
	// smallest value a base of two can reach with degree two
	localparam int                   MIN_POW  = 4;
	localparam logic [DEG_BITS-1:0]  MIN_DEG  = 5'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PICK,
		ST_MUL,
		ST_CHK,
		ST_DONE
	} state_t;

endpackage

// ===== hw/rtl/exact_integer_nth_root_core.sv =====
// ----------------------------------------------------------------------------
// exact_integer_nth_root_core
// Finds the base b >= 2 with b**degree == value, by binary search over
// bases with one shared multiplier raising each probe step by step.
// Sequence: trivial inputs (degree below two or value below four) go from
// IDLE straight to DONE; otherwise each probe runs PICK, then MUL and CHK for
// each multiply step (m <= degree steps), over at most 16 probes, then DONE,
// where the result waits while the output stalls.
// Throughput: one item at a time; s_tready is high only while idle.
// Large probes stop early once the running power passes the value.
// Reset: arst_n clears the sequencer and the output valid; data regs keep.
// ----------------------------------------------------------------------------
module exact_integer_nth_root_core #(
	parameter int VALUE_BITS = einr_pkg::VALUE_BITS_DEF,
	localparam int IN_W  = ((VALUE_BITS + einr_pkg::DEG_BITS + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// value [VALUE_BITS-1:0], degree [VALUE_BITS+4:VALUE_BITS], zero pad above
	input  logic [IN_W-1:0]                s_tdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// base [15:0]
	output logic [einr_pkg::BASE_BITS-1:0] m_tdata,
	// found [0]
	output logic                           m_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready
);

	localparam int BB = einr_pkg::BASE_BITS;
	localparam int DB = einr_pkg::DEG_BITS;
	localparam int PW = VALUE_BITS + BB;

	einr_pkg::state_t state_q, state_d;

	logic [VALUE_BITS-1:0] v_q;
	logic [DB-1:0]         d_q;
	logic [DB-1:0]         k_q;
	logic [BB:0]           lo_q;
	logic [BB-1:0]         hi_q;
	logic [BB-1:0]         mid_q;
	logic [VALUE_BITS-1:0] acc_q;
	logic [PW-1:0]         prod_q;
	logic [BB-1:0]         hit_q;

	logic [BB-1:0]         out_base_q;
	logic                  out_found_q;
	logic                  out_valid_q;

	logic                  in_xfer;
	logic                  trivial;
	logic                  range_empty;
	logic [BB:0]           mid_sum;
	logic                  over;
	logic                  equal;
	logic                  last_step;
	logic                  out_free;
	logic [DB-1:0]         k_next;

	assign in_xfer     = s_tvalid && s_tready;
	assign trivial     = (s_tdata[VALUE_BITS+DB-1:VALUE_BITS] < einr_pkg::MIN_DEG)
		|| (s_tdata[VALUE_BITS-1:0] < VALUE_BITS'(einr_pkg::MIN_POW));
	assign range_empty = lo_q > {1'b0, hi_q};
	assign mid_sum     = lo_q + {1'b0, hi_q};
	assign over        = prod_q > {{BB{1'b0}}, v_q};
	assign equal       = prod_q == {{BB{1'b0}}, v_q};
	assign k_next      = k_q + DB'(1);
	assign last_step   = k_next == d_q;
	assign out_free    = !out_valid_q || m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			einr_pkg::ST_IDLE: begin
				if (in_xfer) begin
					state_d = trivial ? einr_pkg::ST_DONE : einr_pkg::ST_PICK;
				end
			end
			einr_pkg::ST_PICK: begin
				state_d = range_empty ? einr_pkg::ST_DONE : einr_pkg::ST_MUL;
			end
			einr_pkg::ST_MUL: begin
				state_d = einr_pkg::ST_CHK;
			end
			einr_pkg::ST_CHK: begin
				if (over) begin
					state_d = einr_pkg::ST_PICK;
				end else if (last_step) begin
					state_d = equal ? einr_pkg::ST_DONE : einr_pkg::ST_PICK;
				end else begin
					state_d = einr_pkg::ST_MUL;
				end
			end
			einr_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = einr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = einr_pkg::ST_IDLE;
			end
		endcase
	end

	// handshake outputs
	always_comb begin
		s_tready = 1'b0;
		case (state_q)
			einr_pkg::ST_IDLE: s_tready = 1'b1;
			default:           s_tready = 1'b0;
		endcase
	end

	assign m_tdata  = out_base_q;
	assign m_tuser  = out_found_q;
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= einr_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == einr_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// search datapath
	always_ff @(posedge clk) begin
		case (state_q)
			einr_pkg::ST_IDLE: begin
				if (in_xfer) begin
					v_q   <= s_tdata[VALUE_BITS-1:0];
					d_q   <= s_tdata[VALUE_BITS+DB-1:VALUE_BITS];
					lo_q  <= {1'b0, einr_pkg::MIN_BASE};
					hi_q  <= einr_pkg::MAX_BASE;
					hit_q <= '0;
				end
			end
			einr_pkg::ST_PICK: begin
				mid_q <= mid_sum[BB:1];
				acc_q <= VALUE_BITS'(1);
				k_q   <= '0;
			end
			einr_pkg::ST_MUL: begin
				prod_q <= PW'(acc_q) * PW'(mid_q);
			end
			einr_pkg::ST_CHK: begin
				if (over) begin
					hi_q <= mid_q - BB'(1);
				end else begin
					acc_q <= prod_q[VALUE_BITS-1:0];
					k_q   <= k_next;
					if (last_step) begin
						if (equal) begin
							hit_q <= mid_q;
						end else begin
							lo_q <= {1'b0, mid_q} + (BB+1)'(1);
						end
					end
				end
			end
			einr_pkg::ST_DONE: begin
				if (out_free) begin
					out_base_q  <= hit_q;
					out_found_q <= hit_q != '0;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_found_matches_base: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == (m_tdata != '0)))
		else $error("found flag disagrees with base");

	a_step_below_degree: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == einr_pkg::ST_MUL) |-> (k_q < d_q))
		else $error("multiply step count reached degree");

	a_power_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == einr_pkg::ST_MUL) |-> (acc_q <= v_q))
		else $error("running power exceeds value");

	a_lo_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == einr_pkg::ST_PICK) |-> (lo_q >= {1'b0, einr_pkg::MIN_BASE}))
		else $error("search low bound below minimum base");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q != einr_pkg::ST_IDLE))
		else $error("sequencer idle right after input transfer");
`endif

endmodule
